FILE: hw/rtl/kmtp_pkg.sv
package kmtp_pkg;

    // Default sizes of the kit table that the parser fills.
    localparam int MAX_KITS_DEF   = 16;
    localparam int MAX_FILES_DEF  = 4;
    localparam int NAME_LEN_DEF   = 32;
    localparam int PREFIX_LEN_DEF = 8;

    typedef enum logic [2:0] {
        ST_NEWLINE = 3'd0,
        ST_KITNAME = 3'd1,
        ST_MAPPING = 3'd2,
        ST_COMMENT = 3'd3,
        ST_INVALID = 3'd4
    } line_state_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NEWKIT   = 3'd1,
        EV_NAMECH   = 3'd2,
        EV_FILECH   = 3'd3,
        EV_COUNT    = 3'd4,
        EV_OVERFLOW = 3'd5,
        EV_INVALID  = 3'd6
    } event_t;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7E;
    localparam logic [7:0] KEY_NONE     = 8'hFF;
    localparam logic [3:0] PAD_NONE     = 4'd15;

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_upper(c) || is_digit(c) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_fname(input logic [7:0] c);
        return is_upper(c) || is_digit(c) || (c == ".") || (c == "-") || (c == "_");
    endfunction

    // Two-character pad key to pad number; PAD_NONE for an unknown key.
    function automatic logic [3:0] decode_pad(input logic [7:0] a, input logic [7:0] b);
        logic [3:0] pad;
        pad = PAD_NONE;
        if (a == "H" && b == "H") pad = 4'd0;
        if (a == "S" && b == "N") pad = 4'd1;
        if (a == "B" && b == "S") pad = 4'd2;
        if (a == "T" && b == "1") pad = 4'd3;
        if (a == "C" && b == "R") pad = 4'd4;
        if (a == "T" && b == "2") pad = 4'd5;
        if (a == "T" && b == "3") pad = 4'd6;
        if (a == "S" && b == "P") pad = 4'd7;
        if (a == "R" && b == "D") pad = 4'd8;
        if (a == "X" && b == "0") pad = 4'd9;
        if (a == "X" && b == "1") pad = 4'd10;
        return pad;
    endfunction

endpackage

FILE: hw/rtl/kit_mapping_text_parser.sv
// Kit mapping text parser.
// The text channel (text_valid / text_ready / text_byte) takes one byte of
// the mapping text per request. The result channel (res_valid / res_ready)
// returns exactly one write event per byte, in order, with the indices that
// an outside kit table needs to store kit names and filename prefixes.
// A byte accepted into the input register is parsed into the result register
// when that register is free or res_ready is high, and is shown on res_valid
// from there. Throughput is one byte per cycle while the receiver does not
// stall; the parse of one byte is a short decode plus a few narrow counter
// updates between the input register and the result register.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more byte; text_ready falls once both are
// full and rises again in the same cycle that res_ready returns.
// Reset clears the line state, the kit and filename counters and both valid
// flags; the pending key is set to none. Once more kits are started than
// the table holds, the parser reports an overflow and from then on answers
// every byte with no event.
module kit_mapping_text_parser #(
    parameter int MAX_KITS   = kmtp_pkg::MAX_KITS_DEF,
    parameter int MAX_FILES  = kmtp_pkg::MAX_FILES_DEF,
    parameter int NAME_LEN   = kmtp_pkg::NAME_LEN_DEF,
    parameter int PREFIX_LEN = kmtp_pkg::PREFIX_LEN_DEF,
    localparam int KIT_W   = (MAX_KITS > 1) ? $clog2(MAX_KITS) : 1,
    localparam int KTOT_W  = $clog2(MAX_KITS + 1),
    localparam int FILE_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1,
    localparam int FTOT_W  = $clog2(MAX_FILES + 1),
    localparam int CPOS_W  = $clog2((NAME_LEN > PREFIX_LEN) ? NAME_LEN : PREFIX_LEN)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_ready,
    input  logic [7:0]        text_byte,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [2:0]        event_res,
    output logic [KIT_W-1:0]  kit_slot,
    output logic [3:0]        pad_slot,
    output logic [FILE_W-1:0] file_slot,
    output logic [CPOS_W-1:0] char_pos,
    output logic [6:0]        char_value,
    output logic [FTOT_W-1:0] file_total,
    output logic [KTOT_W-1:0] kits_found,
    output logic [2:0]        line_mode
);
    import kmtp_pkg::*;

    localparam int NPOS_W = $clog2(NAME_LEN);
    localparam int FPOS_W = $clog2(PREFIX_LEN);
    localparam logic [NPOS_W-1:0] NAME_LAST   = NPOS_W'(NAME_LEN - 1);
    localparam logic [FPOS_W-1:0] PREFIX_LAST = FPOS_W'(PREFIX_LEN - 1);
    localparam logic [FILE_W-1:0] FILE_LAST   = FILE_W'(MAX_FILES - 1);
    localparam logic [KTOT_W-1:0] KITS_FULL   = KTOT_W'(MAX_KITS);

    // Input stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parser state.
    line_state_t       line_reg, line_next;
    logic              have_kit_reg, have_kit_next;
    logic [KIT_W-1:0]  kit_number_reg, kit_number_next;
    logic [NPOS_W-1:0] name_pos_reg, name_pos_next;
    logic [1:0]        map_pos_reg, map_pos_next;
    logic [7:0]        key_first_reg, key_first_next;
    logic [3:0]        pad_reg, pad_next;
    logic [FILE_W-1:0] file_num_reg, file_num_next;
    logic [FPOS_W-1:0] file_pos_reg, file_pos_next;
    logic              halted_reg, halted_next;
    logic [KTOT_W-1:0] kit_total_reg, kit_total_next;

    // Result register.
    logic              out_valid_reg;
    event_t            ev_reg, ev_next;
    logic [KIT_W-1:0]  kit_slot_reg;
    logic [3:0]        pad_slot_reg;
    logic [FILE_W-1:0] file_slot_reg;
    logic [CPOS_W-1:0] pos_reg, pos_next;
    logic [6:0]        val_reg, val_next;
    logic [FTOT_W-1:0] file_total_reg;
    logic [KTOT_W-1:0] kits_found_reg;
    line_state_t       mode_reg;
    logic              file_fields;

    logic fire;
    logic active;

    // Byte classes and the mapping-line checks, shared by the blocks below.
    logic       c_eol, c_alnum, c_fname, c_comma, c_colon, c_print;
    logic [3:0] pad_decoded;
    logic       map_bad;

    assign fire       = in_valid_reg && (!out_valid_reg || res_ready);
    assign active     = fire && !halted_reg;
    assign text_ready = !in_valid_reg || fire;

    assign c_eol       = is_eol(in_byte_reg);
    assign c_alnum     = is_alnum(in_byte_reg);
    assign c_fname     = is_fname(in_byte_reg);
    assign c_comma     = (in_byte_reg == CH_COMMA);
    assign c_colon     = (in_byte_reg == CH_COLON);
    assign c_print     = (in_byte_reg >= CH_PRINT_LO) && (in_byte_reg <= CH_PRINT_HI);
    assign pad_decoded = decode_pad(key_first_reg, in_byte_reg);

    // A mapping byte that turns the line invalid. Line ends are fine once a
    // kit exists; before any kit every byte of a mapping line is an error.
    always_comb
    begin
        map_bad = 1'b0;
        if (!have_kit_reg) begin
            map_bad = 1'b1;
        end else if (!c_eol) begin
            if (!(c_fname || c_comma || c_colon)) begin
                map_bad = 1'b1;
            end else begin
                case (map_pos_reg)
                    2'd1:    map_bad = (pad_decoded == PAD_NONE);
                    2'd2:    map_bad = !c_colon;
                    2'd3:    map_bad = c_colon;
                    default: map_bad = 1'b0;
                endcase
            end
        end
    end

    // Next line state.
    always_comb
    begin
        line_next = line_reg;
        if (active) begin
            case (line_reg)
                ST_NEWLINE:
                begin
                    if (c_alnum) begin
                        if (kit_total_reg != KITS_FULL) begin
                            line_next = ST_KITNAME;
                        end
                    end else if (in_byte_reg == CH_TAB) begin
                        line_next = ST_MAPPING;
                    end else if (in_byte_reg == CH_HASH) begin
                        line_next = ST_COMMENT;
                    end else if (!c_eol) begin
                        line_next = ST_INVALID;
                    end
                end
                ST_KITNAME:
                begin
                    if (c_eol) begin
                        line_next = ST_NEWLINE;
                    end else if (!c_print) begin
                        line_next = ST_INVALID;
                    end
                end
                ST_MAPPING:
                begin
                    if (map_bad) begin
                        line_next = ST_INVALID;
                    end else if (c_eol) begin
                        line_next = ST_NEWLINE;
                    end
                end
                ST_COMMENT, ST_INVALID:
                begin
                    if (c_eol) begin
                        line_next = ST_NEWLINE;
                    end
                end
                default: line_next = ST_NEWLINE;
            endcase
        end
    end

    // Event, result fields and the counters.
    always_comb
    begin
        ev_next         = EV_NONE;
        pos_next        = '0;
        val_next        = '0;
        file_fields     = 1'b0;
        have_kit_next   = have_kit_reg;
        kit_number_next = kit_number_reg;
        name_pos_next   = name_pos_reg;
        map_pos_next    = map_pos_reg;
        key_first_next  = key_first_reg;
        pad_next        = pad_reg;
        file_num_next   = file_num_reg;
        file_pos_next   = file_pos_reg;
        halted_next     = halted_reg;
        kit_total_next  = kit_total_reg;
        if (active) begin
            case (line_reg)
                ST_NEWLINE:
                begin
                    if (c_alnum) begin
                        if (kit_total_reg == KITS_FULL) begin
                            halted_next = 1'b1;
                            ev_next     = EV_OVERFLOW;
                        end else begin
                            kit_number_next = kit_total_reg[KIT_W-1:0];
                            kit_total_next  = kit_total_reg + 1'b1;
                            have_kit_next   = 1'b1;
                            ev_next         = EV_NEWKIT;
                            val_next        = in_byte_reg[6:0];
                            name_pos_next   = NPOS_W'(1);
                        end
                    end else if (in_byte_reg == CH_TAB) begin
                        map_pos_next   = 2'd0;
                        key_first_next = KEY_NONE;
                        pad_next       = PAD_NONE;
                    end else if (in_byte_reg != CH_HASH && !c_eol) begin
                        ev_next = EV_INVALID;
                    end
                end
                ST_KITNAME:
                begin
                    if (c_print) begin
                        if (name_pos_reg < NAME_LAST) begin
                            ev_next       = EV_NAMECH;
                            pos_next      = CPOS_W'(name_pos_reg);
                            val_next      = in_byte_reg[6:0];
                            name_pos_next = name_pos_reg + 1'b1;
                        end
                    end else if (!c_eol) begin
                        ev_next = EV_INVALID;
                    end
                end
                ST_MAPPING:
                begin
                    if (have_kit_reg && !c_eol) begin
                        // The second key character leaves its decode behind,
                        // also when the key is unknown.
                        if (c_fname || c_comma || c_colon) begin
                            case (map_pos_reg)
                                2'd0: key_first_next = in_byte_reg;
                                2'd1: pad_next = pad_decoded;
                                2'd2:
                                begin
                                    if (c_colon) begin
                                        file_num_next = '0;
                                        file_pos_next = '0;
                                    end
                                end
                                default:
                                begin
                                    if (c_fname) begin
                                        if (file_pos_reg < PREFIX_LAST) begin
                                            ev_next       = EV_FILECH;
                                            pos_next      = CPOS_W'(file_pos_reg);
                                            val_next      = in_byte_reg[6:0];
                                            file_fields   = 1'b1;
                                            file_pos_next = file_pos_reg + 1'b1;
                                        end
                                    end else if (c_comma) begin
                                        if (file_num_reg != FILE_LAST) begin
                                            file_num_next = file_num_reg + 1'b1;
                                        end
                                        file_pos_next = '0;
                                        ev_next       = EV_COUNT;
                                        file_fields   = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    if (map_bad) begin
                        ev_next = EV_INVALID;
                    end
                    if (have_kit_reg && !c_eol && map_pos_reg != 2'd3) begin
                        map_pos_next = map_pos_reg + 1'b1;
                    end
                end
                default: ev_next = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            line_reg       <= ST_NEWLINE;
            have_kit_reg   <= 1'b0;
            kit_number_reg <= '0;
            name_pos_reg   <= '0;
            map_pos_reg    <= '0;
            key_first_reg  <= KEY_NONE;
            pad_reg        <= PAD_NONE;
            file_num_reg   <= '0;
            file_pos_reg   <= '0;
            halted_reg     <= 1'b0;
            kit_total_reg  <= '0;
        end else begin
            if (text_valid && text_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
            line_reg       <= line_next;
            have_kit_reg   <= have_kit_next;
            kit_number_reg <= kit_number_next;
            name_pos_reg   <= name_pos_next;
            map_pos_reg    <= map_pos_next;
            key_first_reg  <= key_first_next;
            pad_reg        <= pad_next;
            file_num_reg   <= file_num_next;
            file_pos_reg   <= file_pos_next;
            halted_reg     <= halted_next;
            kit_total_reg  <= kit_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready) begin
            in_byte_reg <= text_byte;
        end
        if (fire) begin
            ev_reg         <= ev_next;
            kit_slot_reg   <= kit_number_next;
            pad_slot_reg   <= file_fields ? pad_next : 4'd0;
            file_slot_reg  <= file_fields ? file_num_next : '0;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            file_total_reg <= file_fields ? (FTOT_W'(file_num_next) + 1'b1) : '0;
            kits_found_reg <= kit_total_next;
            mode_reg       <= line_next;
        end
    end

    assign res_valid  = out_valid_reg;
    assign event_res  = ev_reg;
    assign kit_slot   = kit_slot_reg;
    assign pad_slot   = pad_slot_reg;
    assign file_slot  = file_slot_reg;
    assign char_pos   = pos_reg;
    assign char_value = val_reg;
    assign file_total = file_total_reg;
    assign kits_found = kits_found_reg;
    assign line_mode  = mode_reg;

    // An overflow is only reported with the kit table full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg == EV_OVERFLOW) |-> (kits_found_reg == KITS_FULL))
        else $error("overflow reported before the kit table is full");

    // Filename events always carry a decoded pad.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (ev_reg == EV_FILECH || ev_reg == EV_COUNT))
            |-> (pad_slot_reg != PAD_NONE))
        else $error("filename event without a valid pad");

    // Once halted, the parser stays halted and the kit count stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> (halted_reg && $stable(kit_total_reg)))
        else $error("parser left the halted state");

    // The kit count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        kit_total_reg <= KITS_FULL)
        else $error("kit count beyond the table size");

endmodule
